>>> rtl/assert_macros.svh
// assertion macros used by key_value_line_parser
// no dependencies; bodies compile away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define KV_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define KV_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define KV_ASSERT(label, clk, rst_n, prop)
`define KV_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

>>> rtl/kvlp_pkg.sv
// types and constants of the key/value line parser
// used by kvlp_step and key_value_line_parser
package kvlp_pkg;

    localparam int MAX_TOKEN_LEN = 256;
    localparam int CNT_W         = $clog2(MAX_TOKEN_LEN);

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    typedef enum logic [2:0] {
        M_PRE_KEY  = 3'd0,
        M_IN_KEY   = 3'd1,
        M_POST_KEY = 3'd2,
        M_PRE_VAL  = 3'd3,
        M_IN_VAL   = 3'd4,
        M_POST_VAL = 3'd5,
        M_COMMENT  = 3'd6,
        M_ERROR    = 3'd7
    } t_mode;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_KEY_CHAR = 3'd1,
        EV_KEY_END  = 3'd2,
        EV_VAL_CHAR = 3'd3,
        EV_COMMIT   = 3'd4,
        EV_ERROR    = 3'd5
    } t_event;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
    } t_kvlp_in;

    typedef struct packed {
        t_event      event_res;
        logic [7:0]  char_out;
        logic [7:0]  char_pos;
        logic [15:0] error_total;
    } t_kvlp_out;

    typedef struct packed {
        t_mode            mode;
        logic [CNT_W-1:0] count;
        logic [15:0]      errs;
    } t_kvlp_state;

endpackage

>>> rtl/kvlp_step.sv
// next state and result of the line parser for one text byte
// depends on kvlp_pkg
module kvlp_step (
    input  kvlp_pkg::t_kvlp_state i_state,
    input  kvlp_pkg::t_kvlp_in    i_item,
    output kvlp_pkg::t_kvlp_state o_state,
    output kvlp_pkg::t_kvlp_out   o_result
);
    import kvlp_pkg::*;

    t_kvlp_state      cur;
    t_mode            m;
    logic [CNT_W-1:0] cnt;
    logic [15:0]      errs;
    logic [15:0]      errs_inc;
    logic [7:0]       ch;
    t_event           ev;
    logic             show;
    logic [CNT_W-1:0] pos;
    logic [CNT_W+7:0] pos_ext;
    logic             overlong;

    always_comb begin
        // file start clears everything before this byte
        if (i_item.file_start) begin
            cur.mode  = M_PRE_KEY;
            cur.count = '0;
            cur.errs  = '0;
        end else begin
            cur = i_state;
        end
        ch       = i_item.data_byte;
        errs_inc = (cur.errs != 16'hFFFF) ? cur.errs + 16'd1 : cur.errs;
        overlong = (cur.count >= CNT_W'(MAX_TOKEN_LEN - 1));
        m    = cur.mode;
        cnt  = cur.count;
        errs = cur.errs;
        ev   = EV_NONE;
        show = 1'b0;
        pos  = '0;

        if (ch == CH_CR || ch == CH_LF) begin
            if (cur.mode == M_IN_KEY || cur.mode == M_POST_KEY) begin
                ev   = EV_ERROR;
                errs = errs_inc;
            end else if (cur.mode == M_PRE_VAL || cur.mode == M_IN_VAL) begin
                ev = EV_COMMIT;
            end
            m   = M_PRE_KEY;
            cnt = '0;
        end else if (ch == CH_HASH) begin
            case (cur.mode)
                M_IN_KEY, M_POST_KEY: begin
                    ev   = EV_ERROR;
                    errs = errs_inc;
                    m    = M_ERROR;
                end
                M_PRE_KEY, M_POST_VAL: begin
                    m = M_COMMENT;
                end
                M_PRE_VAL, M_IN_VAL: begin
                    ev = EV_COMMIT;
                    m  = M_COMMENT;
                end
                default: begin
                end
            endcase
        end else if (ch == CH_EQ) begin
            case (cur.mode)
                M_IN_KEY: begin
                    ev  = EV_KEY_END;
                    cnt = '0;
                    m   = M_PRE_VAL;
                end
                M_POST_KEY: begin
                    m = M_PRE_VAL;
                end
                M_COMMENT, M_ERROR: begin
                end
                default: begin
                    ev   = EV_ERROR;
                    errs = errs_inc;
                    m    = M_ERROR;
                end
            endcase
        end else if (ch == CH_SPACE || ch == CH_TAB) begin
            if (cur.mode == M_IN_KEY) begin
                ev  = EV_KEY_END;
                cnt = '0;
                m   = M_POST_KEY;
            end else if (cur.mode == M_IN_VAL) begin
                ev = EV_COMMIT;
                m  = M_POST_VAL;
            end
        end else begin
            case (cur.mode)
                M_PRE_KEY: begin
                    ev   = EV_KEY_CHAR;
                    cnt  = CNT_W'(1);
                    m    = M_IN_KEY;
                    show = 1'b1;
                end
                M_PRE_VAL: begin
                    ev   = EV_VAL_CHAR;
                    cnt  = CNT_W'(1);
                    m    = M_IN_VAL;
                    show = 1'b1;
                end
                M_IN_KEY, M_IN_VAL: begin
                    if (overlong) begin
                        ev   = EV_ERROR;
                        errs = errs_inc;
                        m    = M_ERROR;
                    end else begin
                        pos  = cur.count;
                        cnt  = cur.count + CNT_W'(1);
                        ev   = (cur.mode == M_IN_KEY) ? EV_KEY_CHAR : EV_VAL_CHAR;
                        show = 1'b1;
                    end
                end
                M_POST_KEY, M_POST_VAL: begin
                    ev   = EV_ERROR;
                    errs = errs_inc;
                    m    = M_ERROR;
                end
                default: begin
                end
            endcase
        end

        // low byte of the token index
        pos_ext = {8'd0, pos};

        o_state.mode          = m;
        o_state.count         = cnt;
        o_state.errs          = errs;
        o_result.event_res    = ev;
        o_result.char_out     = show ? ch : 8'd0;
        o_result.char_pos     = show ? pos_ext[7:0] : 8'd0;
        o_result.error_total  = errs;
    end

endmodule

>>> rtl/key_value_line_parser.sv
// a word taken into the input register is parsed and its result written to the result register once that can move on
// throughput: one text byte per cycle while the output is not stalled, set by the combinational parser state update
// the input register takes a new word whenever the result register moves on
// reset (synchronous, active low) empties both registers and puts the parser
// before a key with zero token length and zero error count
module key_value_line_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  kvlp_pkg::t_kvlp_in  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output kvlp_pkg::t_kvlp_out o_out_item
);
    import kvlp_pkg::*;
`include "assert_macros.svh"

    logic        r_in_valid;
    t_kvlp_in    r_in_item;
    logic        r_out_valid;
    t_kvlp_out   r_out_item;
    t_kvlp_state r_state;
    t_kvlp_state n_state;
    t_kvlp_out   n_out_item;
    logic        fire;

    kvlp_step u_step (
        .i_state  (r_state),
        .i_item   (r_in_item),
        .o_state  (n_state),
        .o_result (n_out_item)
    );

    assign fire       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_state.mode  <= M_PRE_KEY;
            r_state.count <= '0;
            r_state.errs  <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_item <= i_in_item;
        end
        if (fire) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // inside a token the length is never zero
    `KV_ASSERT(a_token_len, i_clk, i_rst_n,
        (r_state.mode == M_IN_KEY || r_state.mode == M_IN_VAL) |-> (r_state.count != '0))
    `KV_ASSERT(a_count_range, i_clk, i_rst_n,
        r_state.count <= CNT_W'(MAX_TOKEN_LEN - 1))
    `KV_ASSERT(a_err_counted, i_clk, i_rst_n,
        (r_out_valid && r_out_item.event_res == EV_ERROR) |-> (r_out_item.error_total != 16'd0))
    `KV_ASSERT(a_no_stall_empty, i_clk, i_rst_n,
        !r_out_valid |-> !o_in_stall)
    `KV_ASSERT(a_state_moves_on_fire, i_clk, i_rst_n,
        !fire |=> $stable(r_state))

endmodule
